// ===== src/wmac_pkg.sv =====
// Shared types, constants and AES helper functions for the M-Bus CTR frame decryptor.
package wmac_pkg;

  localparam int unsigned KeyHalfW  = 64;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [7:0] MinFrameLen  = 8'd19;
  localparam logic [7:0] FirstCipher  = 8'd17;
  localparam logic [CfgIdxW-1:0] CfgKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgKeyLow  = 1'b1;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    ENT_CTR    = 2'd0,
    ENT_CIPHER = 2'd1,
    ENT_ERROR  = 2'd2
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e kind;
    byte_t       data;
    logic [3:0]  idx;
    logic        last;
    logic        grp_start;
  } entry_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t gf_double(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// ===== src/wmac_front.sv =====
// Front end: tracks frame position and turns each accepted byte into a queue entry.
module wmac_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           byte_value_i,
  input  logic                 first_byte_i,
  input  logic [7:0]           frame_length_i,
  output logic                 push_o,
  output wmac_pkg::entry_t     entry_o
);
  import wmac_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic       active_q, active_d;
  logic [7:0] last_pos;
  logic [7:0] k;

  assign last_pos = len_q - 8'd2;
  assign k        = pos_q - FirstCipher;

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    active_d = active_q;
    push_o   = 1'b0;
    entry_o  = '{kind: ENT_CTR, data: byte_value_i, idx: 4'd0, last: 1'b0, grp_start: 1'b0};
    if (accept_i) begin
      if (first_byte_i) begin
        len_d = frame_length_i;
        pos_d = 8'd1;
        if (frame_length_i < MinFrameLen) begin
          active_d      = 1'b0;
          push_o        = 1'b1;
          entry_o.kind  = ENT_ERROR;
          entry_o.data  = 8'd0;
          entry_o.last  = 1'b1;
        end else begin
          active_d = 1'b1;
        end
      end else if (active_q) begin
        if (pos_q != 8'd255) pos_d = pos_q + 8'd1;
        priority if (pos_q >= 8'd2 && pos_q <= 8'd9) begin
          push_o      = 1'b1;
          entry_o.idx = 4'(pos_q - 8'd2);
        end else if (pos_q == 8'd11) begin
          push_o      = 1'b1;
          entry_o.idx = 4'd8;
        end else if (pos_q >= 8'd13 && pos_q <= 8'd16) begin
          push_o      = 1'b1;
          entry_o.idx = 4'(pos_q - 8'd4);
        end else if (pos_q < FirstCipher) begin
          push_o = 1'b0;
        end else if (pos_q > last_pos) begin
          active_d = 1'b0;
        end else begin
          push_o            = 1'b1;
          entry_o.kind      = ENT_CIPHER;
          entry_o.idx       = k[3:0];
          entry_o.grp_start = (k[3:0] == 4'd0);
          entry_o.last      = (pos_q == last_pos);
          if (pos_q == last_pos) active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 8'd0;
      len_q    <= 8'd0;
      active_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== src/wmac_fifo.sv =====
// Two-entry queue between the front end and the back end.
module wmac_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wmac_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output wmac_pkg::entry_t head_o,
  output logic             empty_o
);
  import wmac_pkg::*;

  entry_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== src/wmac_aes.sv =====
// Iterative AES-128 encryption core, one round per cycle with on-the-fly key expansion.
module wmac_aes (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wmac_pkg::BlockW-1:0]  block_i,
  input  logic [wmac_pkg::BlockW-1:0]  key_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [wmac_pkg::BlockW-1:0]  result_o
);
  import wmac_pkg::*;

  byte_t      s_q  [16];
  byte_t      rk_q [16];
  byte_t      t    [16];
  byte_t      m    [16];
  byte_t      nk   [16];
  byte_t      tmp  [4];
  byte_t      all_x;
  byte_t      rcon_q;
  logic [3:0] round_q;
  logic       busy_q, done_q;

  always_comb begin
    tmp[0] = SBOX[rk_q[13]] ^ rcon_q;
    tmp[1] = SBOX[rk_q[14]];
    tmp[2] = SBOX[rk_q[15]];
    tmp[3] = SBOX[rk_q[12]];
    for (int j = 0; j < 4; j++) begin
      nk[j]      = rk_q[j] ^ tmp[j];
      nk[4 + j]  = rk_q[4 + j] ^ nk[j];
      nk[8 + j]  = rk_q[8 + j] ^ nk[4 + j];
      nk[12 + j] = rk_q[12 + j] ^ nk[8 + j];
    end
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[j + 4 * c] = SBOX[s_q[j + 4 * ((c + j) % 4)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all_x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all_x ^ gf_double(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all_x ^ gf_double(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all_x ^ gf_double(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all_x ^ gf_double(t[4*c+3] ^ t[4*c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 16; i++) begin
        s_q[i]  <= block_i[BlockW-1-8*i -: 8] ^ key_i[BlockW-1-8*i -: 8];
        rk_q[i] <= key_i[BlockW-1-8*i -: 8];
      end
      rcon_q <= 8'h01;
    end else if (busy_q) begin
      for (int i = 0; i < 16; i++) begin
        s_q[i]  <= ((round_q == 4'(NumRounds)) ? t[i] : m[i]) ^ nk[i];
        rk_q[i] <= nk[i];
      end
      rcon_q <= gf_double(rcon_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        round_q <= 4'd1;
      end else if (busy_q) begin
        round_q <= round_q + 4'd1;
        if (round_q == 4'(NumRounds)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  always_comb begin
    for (int i = 0; i < 16; i++) result_o[BlockW-1-8*i -: 8] = s_q[i];
  end

endmodule

// ===== src/wmac_back.sv =====
// Back end: owns the counter block and keystream, decrypts bytes into the output register.
module wmac_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  wmac_pkg::entry_t            head_i,
  output logic                        pop_o,
  input  logic [wmac_pkg::BlockW-1:0] key_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  plain_byte_o,
  output logic                        last_byte_o,
  output logic                        too_short_o
);
  import wmac_pkg::*;

  logic [BlockW-1:0] ctr_q, ks_q, aes_res;
  logic              ks_ready_q;
  logic              aes_start, aes_busy, aes_done;
  logic              slot_free, load_out;
  logic              out_valid_q;
  byte_t             pb_q;
  logic              lb_q, ts_q;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    pop_o     = 1'b0;
    load_out  = 1'b0;
    aes_start = 1'b0;
    if (!empty_i) begin
      unique case (head_i.kind)
        ENT_CTR:   pop_o = 1'b1;
        ENT_ERROR: begin
          pop_o    = slot_free;
          load_out = slot_free;
        end
        ENT_CIPHER: begin
          if (!head_i.grp_start || ks_ready_q) begin
            pop_o    = slot_free;
            load_out = slot_free;
          end else begin
            aes_start = !aes_busy && !aes_done;
          end
        end
        default: pop_o = 1'b1;
      endcase
    end
  end

  wmac_aes u_aes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (aes_start),
    .block_i (ctr_q),
    .key_i   (key_i),
    .busy_o  (aes_busy),
    .done_o  (aes_done),
    .result_o(aes_res)
  );

  always_ff @(posedge clk_i) begin
    if (aes_done) ks_q <= aes_res;
    if (load_out) begin
      if (head_i.kind == ENT_ERROR) begin
        pb_q <= 8'd0;
        lb_q <= 1'b1;
        ts_q <= 1'b1;
      end else begin
        pb_q <= head_i.data ^ ks_q[BlockW-1-8*head_i.idx -: 8];
        lb_q <= head_i.last;
        ts_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q       <= '0;
      ks_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (aes_done) begin
        ctr_q      <= ctr_q + BlockW'(1);
        ks_ready_q <= 1'b1;
      end else if (pop_o && head_i.kind == ENT_CTR) begin
        // A fresh header starts at counter byte 0; the three trailing bytes start at zero.
        if (head_i.idx == 4'd0) ctr_q <= {head_i.data, ctr_q[BlockW-9:24], 24'd0};
        else ctr_q[BlockW-1-8*head_i.idx -: 8] <= head_i.data;
      end
      if (pop_o && head_i.kind == ENT_CIPHER && head_i.grp_start) ks_ready_q <= 1'b0;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign plain_byte_o = pb_q;
  assign last_byte_o  = lb_q;
  assign too_short_o  = ts_q;

endmodule

// ===== src/wmbus_aes128_ctr_frame_decrypt.sv =====
// Top level of the wireless M-Bus AES-128 CTR frame decryptor.
//
// Input channel: one frame byte per word (byte_value_i), with first_byte_i marking
// byte 0 and frame_length_i giving the frame length L on that word. Output channel:
// one word per decrypted byte (plain_byte_o), last_byte_o on the byte at index L-2,
// and a single word (0, last, too_short) for a frame with L below 19.
// The key is written through cfg_we_i / cfg_idx_i / cfg_wdata_i: index 0 holds key
// bytes 0..7, index 1 key bytes 8..15, byte 0 in the top bits. Write it only while idle.
//
// The front end classifies each word and pushes header bytes, cipher bytes and error
// marks into a two-entry queue; the back end builds the counter block, runs the AES
// core and holds the result in an output register.
// A result passes through the queue and the output register after its input word is
// accepted. At the first byte of every 16-byte cipher group the back end runs the
// iterative AES core, which takes one round per cycle, and that byte waits for it; the
// rest stream at one word per cycle while the receiver does not stall. Header words
// stream at one word per cycle while the queue has room.
// When the receiver stalls, the output register holds its word, the queue fills, and
// in_ready_o drops after two more words. Reset clears the frame state, the counter
// block, the key and the queue; no word is pending afterwards.
module wmbus_aes128_ctr_frame_decrypt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wmac_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wmac_pkg::KeyHalfW-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      byte_value_i,
  input  logic                            first_byte_i,
  input  logic [7:0]                      frame_length_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      plain_byte_o,
  output logic                            last_byte_o,
  output logic                            too_short_o
);
  import wmac_pkg::*;

  logic [KeyHalfW-1:0] key_high_q, key_low_q;
  logic                accept, push, full, pop, empty;
  entry_t              push_entry, head;

  // Key registers, written directly from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeyHigh: key_high_q <= cfg_wdata_i;
        CfgKeyLow:  key_low_q  <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Every word is taken while the queue has room; dropped bytes simply push nothing.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  wmac_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .byte_value_i  (byte_value_i),
    .first_byte_i  (first_byte_i),
    .frame_length_i(frame_length_i),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  wmac_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(empty)
  );

  wmac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .key_i       ({key_high_q, key_low_q}),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .plain_byte_o(plain_byte_o),
    .last_byte_o (last_byte_o),
    .too_short_o (too_short_o)
  );

endmodule

// ===== src/wmac_checker.sv =====
// Port-level checker for the frame decryptor, bound to the top level.
module wmac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] plain_byte_o,
  input logic       last_byte_o,
  input logic       too_short_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(plain_byte_o) && $stable(last_byte_o) && $stable(too_short_o))
    else $error("output word changed while stalled");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_short_o |-> last_byte_o)
    else $error("error word without last marker");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_short_o |-> plain_byte_o == 8'd0)
    else $error("error word with nonzero data");

endmodule

bind wmbus_aes128_ctr_frame_decrypt wmac_checker u_wmac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .plain_byte_o(plain_byte_o),
  .last_byte_o (last_byte_o),
  .too_short_o (too_short_o)
);

// ===== test/wmbus_aes128_ctr_frame_decrypt_test.sv =====
// Self-checking testbench for the wireless M-Bus AES-128 CTR frame decryptor.
module wmbus_aes128_ctr_frame_decrypt_test;

  // One decrypted word as the block should present it on its output channel.
  typedef struct {
    logic [7:0] plain;
    logic       last;
    logic       short_frame;
  } plain_word_t;

  // Scoreboard: tracks the frame parser, the counter block and the keystream in
  // the same way the block does, and keeps the decrypted words still owed by it.
  class frame_decrypt_scoreboard;
    logic [63:0] key_hi, key_lo;
    logic [7:0]  position, frame_len;
    logic [7:0]  ctr_blk [16];
    logic [7:0]  key_stream [16];
    logic        in_frame;
    plain_word_t owed [$];

    function new();
      key_hi = '0;
      key_lo = '0;
      position = '0;
      frame_len = '0;
      in_frame = 1'b0;
      foreach (ctr_blk[i]) ctr_blk[i] = '0;
      foreach (key_stream[i]) key_stream[i] = '0;
    endfunction

    function void set_key(logic [wmac_pkg::CfgIdxW-1:0] idx, logic [63:0] value);
      if (idx == wmac_pkg::CfgKeyHigh) key_hi = value;
      else key_lo = value;
    endfunction

    static function logic [7:0] xtime(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Encrypts the current counter block into the keystream buffer.
    function void refresh_key_stream();
      logic [7:0] rk [176];
      logic [7:0] st [16];
      logic [7:0] tr [16];
      logic [7:0] w [4];
      logic [7:0] rcon, tmp, a0, a1, a2, a3, mix;
      rcon = 8'h01;
      for (int i = 0; i < 8; i++) begin
        rk[i]     = key_hi[63 - 8*i -: 8];
        rk[8 + i] = key_lo[63 - 8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
        for (int j = 0; j < 4; j++) w[j] = rk[(i-1)*4 + j];
        if ((i % 4) == 0) begin
          tmp  = w[0];
          w[0] = wmac_pkg::SBOX[w[1]] ^ rcon;
          w[1] = wmac_pkg::SBOX[w[2]];
          w[2] = wmac_pkg::SBOX[w[3]];
          w[3] = wmac_pkg::SBOX[tmp];
          rcon = xtime(rcon);
        end
        for (int j = 0; j < 4; j++) rk[i*4 + j] = rk[(i-4)*4 + j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) st[i] = ctr_blk[i] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
        // SubBytes and ShiftRows together; byte index is row + 4 * column.
        for (int c = 0; c < 4; c++)
          for (int j = 0; j < 4; j++)
            tr[j + 4*c] = wmac_pkg::SBOX[st[j + 4*((c + j) % 4)]];
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = tr[4*c]; a1 = tr[4*c+1]; a2 = tr[4*c+2]; a3 = tr[4*c+3];
            mix = a0 ^ a1 ^ a2 ^ a3;
            tr[4*c]   = a0 ^ mix ^ xtime(a0 ^ a1);
            tr[4*c+1] = a1 ^ mix ^ xtime(a1 ^ a2);
            tr[4*c+2] = a2 ^ mix ^ xtime(a2 ^ a3);
            tr[4*c+3] = a3 ^ mix ^ xtime(a3 ^ a0);
          end
        end
        for (int i = 0; i < 16; i++) st[i] = tr[i] ^ rk[r*16 + i];
      end
      foreach (key_stream[i]) key_stream[i] = st[i];
    endfunction

    // Called for every word accepted on the input channel.
    function void note_input(logic [7:0] value, logic first, logic [7:0] len);
      int p, last_pos, k;
      plain_word_t pw;
      if (first) begin
        frame_len = len;
        foreach (ctr_blk[i]) ctr_blk[i] = '0;
        position = 8'd1;
        if (len < 19) begin
          in_frame = 1'b0;
          pw.plain = '0; pw.last = 1'b1; pw.short_frame = 1'b1;
          owed.push_back(pw);
        end else begin
          in_frame = 1'b1;
        end
        return;
      end
      if (!in_frame) return;
      p = position;
      last_pos = int'(frame_len) - 2;
      if (position != 8'd255) position = position + 8'd1;
      if (p >= 2 && p <= 9) ctr_blk[p-2] = value;
      else if (p == 11) ctr_blk[8] = value;
      else if (p >= 13 && p <= 16) ctr_blk[p-4] = value;
      else if (p >= 17) begin
        if (p > last_pos) begin
          in_frame = 1'b0;
          return;
        end
        k = p - 17;
        if ((k % 16) == 0) begin
          refresh_key_stream();
          // 128-bit big-endian increment.
          for (int i = 15; i >= 0; i--) begin
            ctr_blk[i] = ctr_blk[i] + 8'd1;
            if (ctr_blk[i] != 8'd0) break;
          end
        end
        pw.plain = value ^ key_stream[k % 16];
        pw.last = (p == last_pos);
        pw.short_frame = 1'b0;
        owed.push_back(pw);
        if (p == last_pos) in_frame = 1'b0;
      end
    endfunction

    // Compares an output word with the oldest one owed; returns "" when it matches.
    function string check_output(logic [7:0] plain, logic last, logic short_frame);
      plain_word_t pw;
      if (owed.size() == 0)
        return $sformatf("unexpected word plain=%h last=%b too_short=%b",
                         plain, last, short_frame);
      pw = owed.pop_front();
      if (plain !== pw.plain || last !== pw.last || short_frame !== pw.short_frame)
        return $sformatf("got plain=%h last=%b too_short=%b, want %h %b %b",
                         plain, last, short_frame, pw.plain, pw.last, pw.short_frame);
      return "";
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  localparam int StallLimit = 3000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [wmac_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [wmac_pkg::KeyHalfW-1:0] cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [7:0]                    byte_value_i;
  logic                          first_byte_i;
  logic [7:0]                    frame_length_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [7:0]                    plain_byte_o;
  logic                          last_byte_o;
  logic                          too_short_o;

  frame_decrypt_scoreboard sb = new();
  int error_count = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  wmbus_aes128_ctr_frame_decrypt uut (.*);

  always #5 clk_i = ~clk_i;

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  // The receiver stalls at random and checks every word it takes.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && out_ready_i) begin
      msg = sb.check_output(plain_byte_o, last_byte_o, too_short_o);
      if (msg != "") report(msg);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: the run is stuck if neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one word and returns at the edge where it is accepted. The idle gap,
  // if any, comes before the word so valid is only ever dropped between words.
  task automatic send_word(logic [7:0] value, logic first, logic [7:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    byte_value_i   <= value;
    first_byte_i   <= first;
    frame_length_i <= len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(value, first, len);
    words_sent++;
  endtask

  // Sends the first n words of a frame of length len. Words after the first
  // carry random length fields, which the block must ignore.
  task automatic send_frame(int len, int n);
    for (int i = 0; i < n; i++) begin
      if (i == 0) send_word(8'($urandom_range(255)), 1'b1, len[7:0]);
      else send_word(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
    end
  endtask

  // Lowers valid and waits until every owed word has come out, plus the
  // latency of a byte that runs the AES core and yields nothing.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Key is only written while the block is idle, i.e. after drain().
  task automatic write_key(logic [63:0] hi, logic [63:0] lo);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= wmac_pkg::CfgKeyHigh;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    sb.set_key(wmac_pkg::CfgKeyHigh, hi);
    cfg_idx_i   <= wmac_pkg::CfgKeyLow;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    sb.set_key(wmac_pkg::CfgKeyLow, lo);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly complete frames with random content; the rest are short frames,
  // frames cut off by a new first byte, trailing bytes and stray noise.
  task automatic random_traffic(int idle_pct, int stall_pct, int n_words, bit hold_off);
    int target, pick, len, n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = words_sent + n_words;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word(8'($urandom_range(255)), 1'b1, 8'($urandom_range(18)));
      end else if (pick < 14) begin
        repeat ($urandom_range(1, 3))
          send_word(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
      end else begin
        len = ($urandom_range(11) == 0) ? $urandom_range(200, 255) : $urandom_range(19, 70);
        n = ($urandom_range(7) == 0) ? $urandom_range(1, len - 1) : len;
        send_frame(len, n);
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 3))
            send_word(8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)));
      end
      // With hold_off set, the sender waits for the output side to empty completely once per phase.
      if (hold_off && words_sent > target - n_words / 2) begin
        hold_off = 1'b0;
        in_valid_i <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = wmac_pkg::CfgKeyHigh;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    byte_value_i   = '0;
    first_byte_i   = 1'b0;
    frame_length_i = '0;
    out_ready_i    = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the all-zero reset key: a stray byte with no frame,
    // short frames at both ends of the error range, and the shortest valid
    // frame whose single cipher byte is also its last, with extreme bytes.
    send_word(8'hff, 1'b0, 8'hff);
    send_word(8'h00, 1'b1, 8'd0);
    send_word(8'hff, 1'b1, 8'd18);
    send_word(8'h13, 1'b1, 8'd19);
    for (int i = 1; i < 19; i++) send_word((i % 2) ? 8'hff : 8'h00, 1'b0, 8'h00);
    send_word(8'h5a, 1'b0, 8'hff);
    drain();

    random_traffic(0, 0, 230, 1'b0);
    write_key('1, '1);
    random_traffic(71, 0, 230, 1'b0);
    write_key({$urandom, $urandom}, {$urandom, $urandom});
    random_traffic(0, 71, 230, 1'b1);
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    random_traffic(30, 30, 230, 1'b1);
    write_key('0, '1);
    random_traffic(0, 0, 230, 1'b0);

    if (sb.outstanding() != 0) report("words still owed at end of run");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
